// ===== rtl/mts_pkg.sv =====
`default_nettype none
package mts_pkg;
    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take in the accepted item
        logic exec;      // update counts, write stores, launch reads
        logic load;      // refill top caches from store read data
        logic result;    // load the output register
    } t_cmd;
endpackage
`default_nettype wire

// ===== rtl/mts_ctrl.sv =====
`default_nettype none
module mts_ctrl
    import mts_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  s_axis_tvalid,
    output logic s_axis_tready,
    output logic m_axis_tvalid,
    input  wire  m_axis_tready,
    output t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_LOAD   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.result = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mts_datapath.sv =====
`default_nettype none
module mts_datapath
    import mts_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_cmd                     i_cmd,
    input  wire                      i_operation,
    input  wire  signed [DATA_W-1:0] i_value,
    output logic signed [DATA_W-1:0] o_top_value,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic                     o_is_empty,
    output logic [1:0]               o_status
);
    logic signed [DATA_W-1:0] r_val_mem [DEPTH];
    logic signed [DATA_W-1:0] r_min_mem [DEPTH];

    logic                     r_op;
    logic signed [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]         r_vc, n_vc;
    logic [CNT_W-1:0]         r_mc, n_mc;
    logic signed [DATA_W-1:0] r_top, r_min;
    logic signed [DATA_W-1:0] r_val_rd, r_min_rd;
    logic [1:0]               r_status, n_status;
    logic                     r_pop_ok, n_pop_ok;
    logic                     wr_val, wr_min;
    logic                     take;
    logic [CNT_W-1:0]         rd_vc, rd_mc;

    // push goes on the min stack when it is empty or value <= current min
    assign take = (r_mc == '0) || (r_value <= r_min);

    always_comb begin
        n_vc     = r_vc;
        n_mc     = r_mc;
        n_status = ST_OK;
        n_pop_ok = 1'b0;
        wr_val   = 1'b0;
        wr_min   = 1'b0;
        if (r_op == OP_PUSH) begin
            if (r_vc == CNT_W'(DEPTH)) begin
                n_status = ST_OVERFLOW;
            end else begin
                wr_val = 1'b1;
                n_vc   = r_vc + CNT_W'(1);
                if (take && (r_mc < CNT_W'(DEPTH))) begin
                    wr_min = 1'b1;
                    n_mc   = r_mc + CNT_W'(1);
                end
            end
        end else begin
            if (r_vc == '0) begin
                n_status = ST_UNDERFLOW;
            end else begin
                n_pop_ok = 1'b1;
                n_vc     = r_vc - CNT_W'(1);
                if ((r_mc != '0) && (r_min == r_top)) begin
                    n_mc = r_mc - CNT_W'(1);
                end
            end
        end
    end

    // new tops after a pop sit one below the new counts
    assign rd_vc = n_vc - CNT_W'(1);
    assign rd_mc = n_mc - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_val) begin
            r_val_mem[r_vc[ADDR_W-1:0]] <= r_value;
        end
        r_val_rd <= r_val_mem[rd_vc[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_min) begin
            r_min_mem[r_mc[ADDR_W-1:0]] <= r_value;
        end
        r_min_rd <= r_min_mem[rd_mc[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc     <= '0;
            r_mc     <= '0;
            r_pop_ok <= 1'b0;
        end else if (i_cmd.exec) begin
            r_vc     <= n_vc;
            r_mc     <= n_mc;
            r_pop_ok <= n_pop_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            if (wr_val) begin
                r_top <= r_value;
            end
            if (wr_min) begin
                r_min <= r_value;
            end
        end
        if (i_cmd.load && r_pop_ok) begin
            r_top <= r_val_rd;
            r_min <= r_min_rd;
        end
        if (i_cmd.result) begin
            o_top_value <= (r_vc != '0) ? r_top : '0;
            o_min_value <= ((r_vc != '0) && (r_mc != '0)) ? r_min : '0;
            o_is_empty  <= (r_vc == '0);
            o_status    <= r_status;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/min_tracking_stack.sv =====
// min_tracking_stack: LIFO stack of signed 32-bit words that also reports the
// smallest value currently held.
// Input channel (s_axis): tuser carries the operation (0 push, 1 pop), tdata
// the value to push (ignored on a pop). Output channel (m_axis): one result
// transfer per input transfer, giving the new top, the running minimum, an
// empty flag and a status code (ok, overflow on a full push, underflow on an
// empty pop). Overflow and underflow leave the stack untouched.
// Sequencing: after an input transfer the block steps through execute, store
// read-back and output load, and it takes the next item in the cycle after the
// result register is loaded, so it accepts no new item while one is in flight.
// The read-back step is needed because the value and minimum stores are read
// through a register to refill the cached tops after a pop.
// Reset clears both counts and the output valid; store contents are not
// cleared. If the receiver stalls, the result is held in the output register
// and the block waits before loading the next result; no result is dropped.
`default_nettype none
module min_tracking_stack
    import mts_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] value
    input  wire  [0:0]  s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] top_value, [63:32] min_value
    output logic [2:0]  m_axis_tuser    // [0] is_empty, [2:1] status
);
    t_cmd                     cmd;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [1:0]               status;

    // sequencing and output valid
    mts_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd)
    );

    // stores, counts, cached tops, result register
    mts_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (s_axis_tuser[0]),
        .i_value     (s_axis_tdata),
        .o_top_value (top_value),
        .o_min_value (min_value),
        .o_is_empty  (is_empty),
        .o_status    (status)
    );

    assign m_axis_tdata = {min_value, top_value};
    assign m_axis_tuser = {status, is_empty};
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// Checks min_tracking_stack against a scoreboard that mirrors the value
// stack and the running-minimum stack. Directed pushes and pops cover the
// word extremes, ties on the minimum and pops on an empty stack. Random
// walks, and one complete fill that overflows and then drains until it
// underflows, come after that. Both stream sides idle at random.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mts_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
    localparam int HOLD_CYCLES = 80;    // long receiver hold-off
    localparam int HOLD_AFTER  = 150;   // results checked before the hold-off
    localparam int DRAIN_WAIT  = 20;    // settling time at the end of the run

    // ------------------------------------------------------------------
    // Scoreboard: mirrors both stacks, queues the expected result of each
    // input transfer and compares result transfers against it in order.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic signed [DATA_W-1:0] top_val;
        logic signed [DATA_W-1:0] min_val;
        logic                     empty;
        logic [1:0]               status;
    } stack_result_t;

    class stack_scoreboard;
        logic signed [DATA_W-1:0] val_stk [DEPTH];
        logic signed [DATA_W-1:0] min_stk [DEPTH];
        int                       val_cnt;
        int                       min_cnt;
        stack_result_t            pending_results [$];
        int unsigned              errors;
        int unsigned              results_seen;
        int unsigned              n_push, n_pop, n_overflow, n_underflow, peak;

        function new();
            val_cnt = 0;
            min_cnt = 0;
            errors  = 0;
            results_seen = 0;
            n_push = 0; n_pop = 0; n_overflow = 0; n_underflow = 0; peak = 0;
        endfunction

        function int depth();
            return val_cnt;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Apply one accepted operation to the shadow stacks and queue its result.
        function void note_transfer(logic op, logic signed [DATA_W-1:0] v);
            stack_result_t r;
            logic          take;
            r.status = ST_OK;
            if (op == OP_PUSH) begin
                n_push++;
                if (val_cnt >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                    n_overflow++;
                end else begin
                    // ties go on the minimum stack again
                    take = (min_cnt == 0);
                    if (!take)
                        take = (v <= min_stk[min_cnt-1]);
                    val_stk[val_cnt] = v;
                    val_cnt++;
                    if (take && min_cnt < DEPTH) begin
                        min_stk[min_cnt] = v;
                        min_cnt++;
                    end
                end
            end else begin
                n_pop++;
                if (val_cnt == 0) begin
                    r.status = ST_UNDERFLOW;
                    n_underflow++;
                end else begin
                    if (min_cnt > 0 && min_stk[min_cnt-1] == val_stk[val_cnt-1])
                        min_cnt--;
                    val_cnt--;
                end
            end
            if (val_cnt > peak)
                peak = val_cnt;
            r.top_val = (val_cnt > 0) ? val_stk[val_cnt-1] : '0;
            r.min_val = (val_cnt > 0 && min_cnt > 0) ? min_stk[min_cnt-1] : '0;
            r.empty   = (val_cnt == 0);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void flag_error(string what, logic [DATA_W-1:0] exp_v,
                                 logic [DATA_W-1:0] got_v);
            errors++;
            if (errors <= 10)
                $display("[%0t] result %0d: %s expected %h, got %h",
                         $time, results_seen, what, exp_v, got_v);
        endfunction

        function void check_result(logic [63:0] data, logic [2:0] flags);
            stack_result_t e;
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] result %0d arrived with nothing outstanding",
                             $time, results_seen);
                return;
            end
            e = pending_results.pop_front();
            if (data[31:0] !== e.top_val)
                flag_error("top_value", e.top_val, data[31:0]);
            if (data[63:32] !== e.min_val)
                flag_error("min_value", e.min_val, data[63:32]);
            if (flags[0] !== e.empty)
                flag_error("is_empty", DATA_W'(e.empty), DATA_W'(flags[0]));
            if (flags[2:1] !== e.status)
                flag_error("status", DATA_W'(e.status), DATA_W'(flags[2:1]));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [31:0] value
    logic [0:0]  s_axis_tuser;    // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;    // [31:0] top_value, [63:32] min_value
    logic [2:0]  m_axis_tuser;    // [0] is_empty, [2:1] status

    stack_scoreboard sb = new();
    bit              steady;      // both sides stop idling while set
    int unsigned     items_sent;

    min_tracking_stack u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_draw();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    // Mix of small values (to force ties), full-range words and extremes.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 32'($signed($urandom_range(0, 16)) - 8);
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One input transfer; tvalid stays high into the next call when no gap is drawn.
    task automatic send_op(logic op, logic [31:0] v);
        int gap;
        gap = idle_draw();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_transfer(op, v);
        items_sent++;
    endtask

    task automatic random_walk(int n, int push_pct);
        repeat (n) begin
            if ($urandom_range(0, 99) < push_pct)
                send_op(OP_PUSH, rand_word());
            else
                send_op(OP_POP, $urandom);   // data is don't-care on a pop
        end
    endtask

    // Fill to capacity, push into a full stack, then drain past empty.
    task automatic fill_and_drain();
        logic signed [31:0] floor_val;
        floor_val = '0;
        while (sb.depth() < DEPTH) begin
            if ($urandom_range(0, 1)) begin
                // non-increasing run keeps the minimum stack growing, with ties
                floor_val = floor_val - $urandom_range(0, 2);
                send_op(OP_PUSH, floor_val);
            end else begin
                send_op(OP_PUSH, rand_word());
            end
        end
        repeat (3) send_op(OP_PUSH, rand_word());
        send_op(OP_POP, $urandom);
        send_op(OP_PUSH, rand_word());
        repeat (2) send_op(OP_PUSH, rand_word());
        while (sb.depth() > 0)
            send_op(OP_POP, $urandom);
        repeat (3) send_op(OP_POP, $urandom);
    endtask

    // Withdraw the offer, then wait until every result has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off, so the block
    // stalls its input while the sender keeps offering.
    // ------------------------------------------------------------------
    initial begin : receiver
        int gap;
        bit held;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = idle_draw();
            if (!held && sb.results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: ends the run if nothing moves on either side for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] no transfer for %0d cycles, giving up", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUSH;
        m_axis_tready = 1'b0;
        steady        = 1'b0;
        items_sent    = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, word extremes, duplicate minima, ignored pop data
        send_op(OP_POP,  32'h0000_0000);
        send_op(OP_PUSH, 32'h0000_0000);
        send_op(OP_PUSH, 32'h7fff_ffff);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'hffff_ffff);
        send_op(OP_PUSH, 32'h0000_0005);
        send_op(OP_POP,  32'hffff_ffff);
        repeat (6) send_op(OP_POP, 32'h0000_0000);
        send_op(OP_POP,  32'hffff_ffff);
        send_op(OP_PUSH, 32'h0000_0003);
        send_op(OP_PUSH, 32'h0000_0003);
        send_op(OP_PUSH, 32'h0000_0002);
        send_op(OP_PUSH, 32'h0000_0007);
        send_op(OP_PUSH, 32'h0000_0002);
        repeat (5) send_op(OP_POP, 32'h0000_0000);

        // random walk, long receiver hold-off lands in here
        random_walk(350, 60);

        // sender pauses until the block has answered everything
        wait_for_results();

        steady = 1'b1;
        fill_and_drain();
        steady = 1'b0;

        // back-to-back stretch, then idling again up to the item target
        steady = 1'b1;
        random_walk(60, 55);
        steady = 1'b0;
        while (items_sent < ITEM_TARGET)
            random_walk(1, 50);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d transfers: %0d pushes (%0d overflow), %0d pops (%0d underflow)",
                 items_sent, sb.n_push, sb.n_overflow, sb.n_pop, sb.n_underflow);
        $display("Peak depth %0d of %0d, %0d results checked, %0d errors",
                 sb.peak, DEPTH, sb.results_seen, sb.errors + sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/mts_pkg.sv
rtl/mts_ctrl.sv
rtl/mts_datapath.sv
rtl/min_tracking_stack.sv
tb/tb_top.sv
